FILE: rtl/bmm_pkg.sv
package bmm_pkg;

  // Number of configured moduli and the register map derived from it.
  localparam int NumModuli      = 2;
  localparam int RegsPerModulus = 3;
  localparam int RegModulus     = 0;
  localparam int RegRatioLow    = 1;
  localparam int RegRatioHigh   = 2;
  localparam int CfgIdxW        = $clog2(RegsPerModulus * NumModuli);
  localparam int ModSelW        = (NumModuli > 1) ? $clog2(NumModuli) : 1;

  // Datapath widths.
  localparam int ValueW   = 61;
  localparam int WordW    = 64;
  localparam int LimbW    = 32;
  localparam int ProdW    = 2 * WordW;
  localparam int WideW    = 3 * WordW;
  localparam int LimbIdxW = 2;
  localparam int OffW     = 3;
  localparam int StepW    = 4;

  localparam logic [ValueW-1:0] ModulusReset = ValueW'(2);

  // Last step index of each multiply phase.
  localparam logic [StepW-1:0] ProdLastStep = StepW'(3);
  localparam logic [StepW-1:0] QuotLastStep = StepW'(15);
  localparam logic [StepW-1:0] ReduLastStep = StepW'(2);

  // Which operand pair the shared multiplier works on.
  typedef enum logic [1:0] {
    PH_PROD,
    PH_QUOT,
    PH_REDU
  } bmm_phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_PWAIT,
    S_QUOT,
    S_QWAIT,
    S_REDU,
    S_RWAIT,
    S_REM,
    S_ACC
  } bmm_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                issue;
    bmm_phase_e          phase;
    logic [LimbIdxW-1:0] limb_x;
    logic [LimbIdxW-1:0] limb_y;
    logic                rem_en;
    logic                acc_en;
  } bmm_cmd_t;

endpackage

FILE: rtl/bmm_if.sv
// Input channel: one pair of residues per transaction.
interface bmm_in_if;
  logic                       valid;
  logic                       ready;
  logic [bmm_pkg::ValueW-1:0] left_value;
  logic [bmm_pkg::ValueW-1:0] right_value;
  logic                       modulus_select;
  logic                       last;

  modport source (output valid, output left_value, output right_value,
                  output modulus_select, output last, input ready);
  modport sink (input valid, input left_value, input right_value,
                input modulus_select, input last, output ready);
endinterface

// Output channel: one finished dot product per transaction.
interface bmm_out_if;
  logic                       valid;
  logic                       ready;
  logic [bmm_pkg::ValueW-1:0] sum;

  modport source (output valid, output sum, input ready);
  modport sink (input valid, input sum, output ready);
endinterface

// Configuration write channel.
interface bmm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bmm_pkg::CfgIdxW-1:0] reg_index;
  logic [bmm_pkg::WordW-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: rtl/bmm_datapath.sv
module bmm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bmm_pkg::bmm_cmd_t            cmd_i,
  input  logic [bmm_pkg::ValueW-1:0]   left_value_i,
  input  logic [bmm_pkg::ValueW-1:0]   right_value_i,
  input  logic                         modulus_select_i,
  input  logic                         last_i,
  input  logic                         cfg_we_i,
  input  logic [bmm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bmm_pkg::WordW-1:0]    cfg_wdata_i,
  output logic                         last_o,
  output logic [bmm_pkg::ValueW-1:0]   sum_o
);

  // Configuration registers, one set per modulus.
  logic [bmm_pkg::ValueW-1:0] modulus_q    [bmm_pkg::NumModuli];
  logic [bmm_pkg::WordW-1:0]  ratio_low_q  [bmm_pkg::NumModuli];
  logic [bmm_pkg::WordW-1:0]  ratio_high_q [bmm_pkg::NumModuli];

  // Operands of the current item.
  logic [bmm_pkg::ValueW-1:0]  a_q, b_q;
  logic                        sel_q, last_q;
  logic [bmm_pkg::ModSelW-1:0] sel_idx;

  // Partial product accumulators of the three multiply phases.
  logic [bmm_pkg::ProdW-1:0] p_q;
  logic [bmm_pkg::WideW-1:0] w_q;
  logic [bmm_pkg::WordW-1:0] qn_q;

  // Multiplier output stage.
  logic [bmm_pkg::WordW-1:0] mul_d, mul_q;
  logic [bmm_pkg::OffW-1:0]  mul_off_d, mul_off_q;
  bmm_pkg::bmm_phase_e       mul_phase_q;
  logic                      mul_vld_q;

  logic [bmm_pkg::ProdW-1:0]       x_src, y_src;
  logic [bmm_pkg::LimbW-1:0]       x_limb, y_limb;
  logic [bmm_pkg::WideW+bmm_pkg::WordW-1:0] shifted;
  logic [bmm_pkg::WordW-1:0]       n_word;
  logic [bmm_pkg::WordW-1:0]       r_raw, r_red, s_raw, s_red;
  logic [bmm_pkg::ValueW-1:0]      r_q, acc_q, sum_q;

  // Configuration writes, decoded per modulus.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bmm_pkg::NumModuli; k++) begin
        modulus_q[k]    <= bmm_pkg::ModulusReset;
        ratio_low_q[k]  <= '0;
        ratio_high_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int k = 0; k < bmm_pkg::NumModuli; k++) begin
        if (cfg_index_i == bmm_pkg::CfgIdxW'(k * bmm_pkg::RegsPerModulus +
                                              bmm_pkg::RegModulus)) begin
          modulus_q[k] <= cfg_wdata_i[bmm_pkg::ValueW-1:0];
        end
        if (cfg_index_i == bmm_pkg::CfgIdxW'(k * bmm_pkg::RegsPerModulus +
                                              bmm_pkg::RegRatioLow)) begin
          ratio_low_q[k] <= cfg_wdata_i;
        end
        if (cfg_index_i == bmm_pkg::CfgIdxW'(k * bmm_pkg::RegsPerModulus +
                                              bmm_pkg::RegRatioHigh)) begin
          ratio_high_q[k] <= cfg_wdata_i;
        end
      end
    end
  end

  // Capture the operands when an item is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= left_value_i;
      b_q    <= right_value_i;
      sel_q  <= modulus_select_i;
      last_q <= last_i;
    end
  end

  // A select beyond the configured moduli falls back to the first one.
  assign sel_idx = (int'(sel_q) < bmm_pkg::NumModuli) ? bmm_pkg::ModSelW'(sel_q) : '0;
  assign n_word  = bmm_pkg::WordW'(modulus_q[sel_idx]);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.phase)
      bmm_pkg::PH_PROD: begin
        x_src = bmm_pkg::ProdW'(a_q);
        y_src = bmm_pkg::ProdW'(b_q);
      end
      bmm_pkg::PH_QUOT: begin
        x_src = p_q;
        y_src = {ratio_high_q[sel_idx], ratio_low_q[sel_idx]};
      end
      bmm_pkg::PH_REDU: begin
        x_src = bmm_pkg::ProdW'(w_q[bmm_pkg::WideW-1:bmm_pkg::ProdW]);
        y_src = bmm_pkg::ProdW'(n_word);
      end
      default: begin
        x_src = '0;
        y_src = '0;
      end
    endcase
  end

  assign x_limb    = x_src[bmm_pkg::LimbW*cmd_i.limb_x +: bmm_pkg::LimbW];
  assign y_limb    = y_src[bmm_pkg::LimbW*cmd_i.limb_y +: bmm_pkg::LimbW];
  assign mul_d     = bmm_pkg::WordW'(x_limb) * bmm_pkg::WordW'(y_limb);
  assign mul_off_d = bmm_pkg::OffW'(cmd_i.limb_x) + bmm_pkg::OffW'(cmd_i.limb_y);

  // Multiplier output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      mul_q       <= mul_d;
      mul_off_q   <= mul_off_d;
      mul_phase_q <= cmd_i.phase;
    end
  end

  // Align the partial product to its limb position.
  assign shifted = {{bmm_pkg::WideW{1'b0}}, mul_q} << (bmm_pkg::LimbW * int'(mul_off_q));

  // Accumulate partial products; bits above each register's width drop out.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q  <= '0;
      w_q  <= '0;
      qn_q <= '0;
    end else if (mul_vld_q) begin
      case (mul_phase_q)
        bmm_pkg::PH_PROD: p_q  <= p_q + shifted[bmm_pkg::ProdW-1:0];
        bmm_pkg::PH_QUOT: w_q  <= w_q + shifted[bmm_pkg::WideW-1:0];
        bmm_pkg::PH_REDU: qn_q <= qn_q + shifted[bmm_pkg::WordW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Remainder with one conditional subtraction, formed modulo 2^64.
  assign r_raw = p_q[bmm_pkg::WordW-1:0] - qn_q;
  assign r_red = (r_raw >= n_word) ? r_raw - n_word : r_raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rem_en) begin
      r_q <= r_red[bmm_pkg::ValueW-1:0];
    end
  end

  // Modular accumulate; the last item hands the sum out and clears.
  assign s_raw = bmm_pkg::WordW'(acc_q) + bmm_pkg::WordW'(r_q);
  assign s_red = (s_raw >= n_word) ? s_raw - n_word : s_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= last_q ? '0 : s_red[bmm_pkg::ValueW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en && last_q) begin
      sum_q <= s_red[bmm_pkg::ValueW-1:0];
    end
  end

  assign last_o = last_q;
  assign sum_o  = sum_q;

endmodule

FILE: rtl/bmm_controller.sv
module bmm_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              last_i,
  output bmm_pkg::bmm_cmd_t cmd_o
);

  bmm_pkg::bmm_state_e          state_q, state_d;
  logic [bmm_pkg::StepW-1:0]    step_q, step_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_blocked;

  // State, step counter and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmm_pkg::S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A pending result that is not taken this cycle blocks the next one.
  assign out_blocked = out_valid_q && !out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.phase  = bmm_pkg::PH_PROD;

    case (state_q)
      bmm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = bmm_pkg::S_PROD;
        end
      end
      bmm_pkg::S_PROD: begin
        cmd_o.issue  = 1'b1;
        cmd_o.phase  = bmm_pkg::PH_PROD;
        cmd_o.limb_x = {1'b0, step_q[1]};
        cmd_o.limb_y = {1'b0, step_q[0]};
        step_d       = step_q + 1'b1;
        if (step_q == bmm_pkg::ProdLastStep) begin
          state_d = bmm_pkg::S_PWAIT;
        end
      end
      bmm_pkg::S_PWAIT: begin
        step_d  = '0;
        state_d = bmm_pkg::S_QUOT;
      end
      bmm_pkg::S_QUOT: begin
        cmd_o.issue  = 1'b1;
        cmd_o.phase  = bmm_pkg::PH_QUOT;
        cmd_o.limb_x = step_q[3:2];
        cmd_o.limb_y = step_q[1:0];
        step_d       = step_q + 1'b1;
        if (step_q == bmm_pkg::QuotLastStep) begin
          state_d = bmm_pkg::S_QWAIT;
        end
      end
      bmm_pkg::S_QWAIT: begin
        step_d  = '0;
        state_d = bmm_pkg::S_REDU;
      end
      bmm_pkg::S_REDU: begin
        // Only limb pairs that land in the low 64 bits of q*n are needed.
        cmd_o.issue  = 1'b1;
        cmd_o.phase  = bmm_pkg::PH_REDU;
        cmd_o.limb_x = {1'b0, step_q[1]};
        cmd_o.limb_y = {1'b0, step_q[0]};
        step_d       = step_q + 1'b1;
        if (step_q == bmm_pkg::ReduLastStep) begin
          state_d = bmm_pkg::S_RWAIT;
        end
      end
      bmm_pkg::S_RWAIT: begin
        cmd_o.phase = bmm_pkg::PH_REDU;
        state_d     = bmm_pkg::S_REM;
      end
      bmm_pkg::S_REM: begin
        cmd_o.phase  = bmm_pkg::PH_REDU;
        cmd_o.rem_en = 1'b1;
        state_d      = bmm_pkg::S_ACC;
      end
      bmm_pkg::S_ACC: begin
        cmd_o.phase = bmm_pkg::PH_REDU;
        if (!(last_i && out_blocked)) begin
          cmd_o.acc_en = 1'b1;
          state_d      = bmm_pkg::S_IDLE;
          if (last_i) begin
            out_valid_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = bmm_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/barrett_modular_mac.sv
// Barrett modular multiply-accumulate.
// Input channel in_i carries left_value, right_value, modulus_select and last.
// Each pair is multiplied, reduced modulo the selected modulus with its
// 128-bit Barrett ratio, and added into a running modular sum. When the pair
// marked last has been added, the sum is sent on out_o and the sum clears.
// Configuration channel cfg_i writes the modulus and ratio registers by
// index; it is always ready. The user must see that it is written only while
// the block is idle; the block itself does not enforce this.
// From one input transaction to the next possible one, a single 32x32
// multiplier works through 4 limb products for the operand product, 16 for
// the quotient and 3 for q*n, with a drain state after each phase, then a
// state for the remainder, one for the add, and the idle state in which the
// next item is taken. The result goes to out_o once the last pair is added.
// The result sits in an output register, so the next item is taken while it
// waits; only a following last item stalls, before its add, until the
// pending result is taken.
// Reset clears the running sum and the valid flags, and sets both moduli to
// 2 and both ratios to 0.
module barrett_modular_mac (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmm_in_if.sink     in_i,
  bmm_out_if.source  out_o,
  bmm_cfg_if.sink    cfg_i
);

  bmm_pkg::bmm_cmd_t cmd;
  logic              item_last;

  assign cfg_i.ready = 1'b1;

  bmm_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .last_i      (item_last),
    .cmd_o       (cmd)
  );

  bmm_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .left_value_i     (in_i.left_value),
    .right_value_i    (in_i.right_value),
    .modulus_select_i (in_i.modulus_select),
    .last_i           (in_i.last),
    .cfg_we_i         (cfg_i.valid),
    .cfg_index_i      (cfg_i.reg_index),
    .cfg_wdata_i      (cfg_i.wdata),
    .last_o           (item_last),
    .sum_o            (out_o.sum)
  );

  // An item is loaded exactly on an input transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_i.valid && in_i.ready))
    else $error("operands loaded without an input transaction");

  // Items are worked one at a time: no new item right after one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while the previous item is in progress");

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.acc_en && item_last) |-> !(out_o.valid && !out_o.ready))
    else $error("pending result overwritten");

  // A result appears only after the add of a last item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.acc_en && item_last))
    else $error("result valid without a finished dot product");

endmodule
